FILE: rtl/pptg_pkg.sv
// ----------------------------------------------------------------------------
// pptg_pkg
// Shared types and constants of the primitive triple generator: widths,
// multiplier operand codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pptg_pkg;

  // widths of the enumeration values and results
  localparam int unsigned U_W    = 17;  // outer and inner values
  localparam int unsigned CAND_W = 18;  // search candidate, may step past u
  localparam int unsigned SQ_W   = 34;  // square or product of two values
  localparam int unsigned LEG_W  = 35;  // full width of b and c
  localparam int unsigned OUT_W  = 33;  // width of the result fields

  localparam int unsigned LIMIT_RESET = 100;

  // operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MUL_UU,
    MUL_VV,
    MUL_UV
  } mul_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load;            // item accepted, apply restart
    logic     cand_from_v;     // candidate = stored next v
    logic     cand_from_vsel;  // candidate = chosen v + 2
    logic     cand_inc;        // candidate += 2
    logic     gcd_init;        // load gcd operands with u and candidate
    logic     gcd_step;        // one binary gcd step
    logic     vsel_load;       // candidate becomes the chosen v
    logic     mul_en;          // multiply, shift the product line
    mul_sel_e mul_sel;
    logic     legs;            // form a, b and c
    logic     finish;          // row end check and state update
    logic     out_load;        // load the result register
    logic     out_exh;         // result is the exhausted item
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finished;
    logic cand_ge_u;
    logic gcd_done;
    logic coprime;
  } status_t;

endpackage

FILE: rtl/pptg_datapath.sv
// ----------------------------------------------------------------------------
// pptg_datapath
// Enumeration state, limit register, binary gcd unit, shared 17x17
// multiplier with its product line, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pptg_datapath #(
  parameter int unsigned LIMIT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pptg_pkg::cmd_t                   cmd_i,
  output pptg_pkg::status_t                status_o,
  input  logic                             restart_i,
  input  logic                             cfg_we_i,
  input  logic [LIMIT_WIDTH-1:0]           cfg_wdata_i,
  output logic [pptg_pkg::OUT_W-1:0]       leg_odd_o,
  output logic [pptg_pkg::OUT_W-1:0]       leg_even_o,
  output logic [pptg_pkg::OUT_W-1:0]       hypotenuse_o,
  output logic                             is_last_o,
  output logic                             exhausted_o
);

  localparam int unsigned CMP_W =
    (LIMIT_WIDTH > pptg_pkg::LEG_W) ? LIMIT_WIDTH : pptg_pkg::LEG_W;

  logic [LIMIT_WIDTH-1:0]         limit_q;
  logic [pptg_pkg::U_W-1:0]       u_q, v_q, vsel_q, gx_q, gy_q;
  logic [pptg_pkg::CAND_W-1:0]    cand_q;
  logic                           fin_q;
  logic [pptg_pkg::SQ_W-1:0]      prod_q, p1_q, p2_q, a_q;
  logic [pptg_pkg::LEG_W-1:0]     b_q, c_q;
  logic [pptg_pkg::U_W-1:0]       mul_x, mul_y;
  logic [pptg_pkg::SQ_W-1:0]      mul_p;
  logic                           end_row, over, u_max;
  logic [pptg_pkg::U_W-1:0]       v_row;
  logic [CMP_W-1:0]               a_ext, b_ext, lim_ext;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_WIDTH'(pptg_pkg::LIMIT_RESET);
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // row end and limit checks
  assign a_ext   = CMP_W'(a_q);
  assign b_ext   = CMP_W'(b_q);
  assign lim_ext = CMP_W'(limit_q);
  assign u_max   = (u_q == {pptg_pkg::U_W{1'b1}});
  assign end_row = (cand_q >= {1'b0, u_q});
  assign over    = (a_ext > lim_ext) || (b_ext > lim_ext) || u_max;
  // first v of the next row: 1 when it is even, 2 when it is odd
  assign v_row   = u_q[0] ? pptg_pkg::U_W'(1) : pptg_pkg::U_W'(2);

  // enumeration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q   <= pptg_pkg::U_W'(2);
      v_q   <= pptg_pkg::U_W'(1);
      fin_q <= 1'b0;
    end else if (cmd_i.load && restart_i) begin
      u_q   <= pptg_pkg::U_W'(2);
      v_q   <= pptg_pkg::U_W'(1);
      fin_q <= 1'b0;
    end else if (cmd_i.finish) begin
      if (!end_row) begin
        v_q <= cand_q[pptg_pkg::U_W-1:0];
      end else if (over) begin
        fin_q <= 1'b1;
      end else begin
        u_q <= u_q + pptg_pkg::U_W'(1);
        v_q <= v_row;
      end
    end
  end

  // candidate and chosen v
  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_from_v) begin
      cand_q <= {1'b0, v_q};
    end else if (cmd_i.cand_from_vsel) begin
      cand_q <= {1'b0, vsel_q} + pptg_pkg::CAND_W'(2);
    end else if (cmd_i.cand_inc) begin
      cand_q <= cand_q + pptg_pkg::CAND_W'(2);
    end
    if (cmd_i.vsel_load) begin
      vsel_q <= cand_q[pptg_pkg::U_W-1:0];
    end
  end

  // binary gcd, one step per cycle, stops when one side is zero or both even
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      gx_q <= u_q;
      gy_q <= cand_q[pptg_pkg::U_W-1:0];
    end else if (cmd_i.gcd_step) begin
      if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else if (gx_q >= gy_q) begin
        gx_q <= gx_q - gy_q;
      end else begin
        gy_q <= gy_q - gx_q;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      pptg_pkg::MUL_UU: begin
        mul_x = u_q;
        mul_y = u_q;
      end
      pptg_pkg::MUL_VV: begin
        mul_x = vsel_q;
        mul_y = vsel_q;
      end
      pptg_pkg::MUL_UV: begin
        mul_x = u_q;
        mul_y = vsel_q;
      end
      default: begin
        mul_x = u_q;
        mul_y = u_q;
      end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // product line, then the legs from the three products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
      p1_q   <= prod_q;
      p2_q   <= p1_q;
    end
    if (cmd_i.legs) begin
      a_q <= p2_q - p1_q;
      b_q <= {prod_q, 1'b0};
      c_q <= {1'b0, p2_q} + {1'b0, p1_q};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_exh) begin
        leg_odd_o    <= '0;
        leg_even_o   <= '0;
        hypotenuse_o <= '0;
        is_last_o    <= 1'b0;
        exhausted_o  <= 1'b1;
      end else begin
        leg_odd_o    <= a_q[pptg_pkg::OUT_W-1:0];
        leg_even_o   <= b_q[pptg_pkg::OUT_W-1:0];
        hypotenuse_o <= c_q[pptg_pkg::OUT_W-1:0];
        is_last_o    <= end_row && over;
        exhausted_o  <= 1'b0;
      end
    end
  end

  // status
  assign status_o.finished  = fin_q;
  assign status_o.cand_ge_u = end_row;
  assign status_o.gcd_done  = (gx_q == '0) || (gy_q == '0) || (!gx_q[0] && !gy_q[0]);
  assign status_o.coprime   = ((gx_q == '0) && (gy_q == pptg_pkg::U_W'(1))) ||
                              ((gy_q == '0) && (gx_q == pptg_pkg::U_W'(1)));

endmodule

FILE: rtl/pptg_controller.sv
// ----------------------------------------------------------------------------
// pptg_controller
// Sequencer of one item: restart, coprime search for v, the three
// multiplies, search for the next v, row end update and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pptg_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pptg_pkg::status_t   status_i,
  output pptg_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_TEST   = 4'd2;
  localparam logic [3:0] S_GCD    = 4'd3;
  localparam logic [3:0] S_MUL_UU = 4'd4;
  localparam logic [3:0] S_MUL_VV = 4'd5;
  localparam logic [3:0] S_MUL_UV = 4'd6;
  localparam logic [3:0] S_LEGS   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       phase_q, phase_d;  // 0: search for this v, 1: for the next one
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.mul_sel = pptg_pkg::MUL_UU;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.finished) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_exh  = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.cand_from_v = 1'b1;
          phase_d           = 1'b0;
          state_d           = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.cand_ge_u) begin
          if (phase_q) begin
            state_d = S_FIN;
          end else begin
            cmd_o.vsel_load = 1'b1;
            state_d         = S_MUL_UU;
          end
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (!status_i.gcd_done) begin
          cmd_o.gcd_step = 1'b1;
        end else if (!status_i.coprime) begin
          cmd_o.cand_inc = 1'b1;
          state_d        = S_TEST;
        end else if (phase_q) begin
          state_d = S_FIN;
        end else begin
          cmd_o.vsel_load = 1'b1;
          state_d         = S_MUL_UU;
        end
      end
      S_MUL_UU: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pptg_pkg::MUL_UU;
        state_d       = S_MUL_VV;
      end
      S_MUL_VV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pptg_pkg::MUL_VV;
        state_d       = S_MUL_UV;
      end
      S_MUL_UV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pptg_pkg::MUL_UV;
        state_d       = S_LEGS;
      end
      S_LEGS: begin
        cmd_o.legs           = 1'b1;
        cmd_o.cand_from_vsel = 1'b1;
        phase_d              = 1'b1;
        state_d              = S_TEST;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.finish   = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/primitive_pythagorean_triple_generator_unit.sv
// ----------------------------------------------------------------------------
// primitive_pythagorean_triple_generator_unit
// Each input item returns the next primitive Pythagorean triple by Euclid's
// formula, a = u*u - v*v, b = 2*u*v, c = u*u + v*v, with u from 2 upward and
// v of opposite parity below u and coprime to it. When a row of u ends and
// its last triple has a or b above the limit register, or u is at its
// maximum, that triple is marked last and later items report exhausted
// until an item with restart set. One item is in work at a time. An item
// runs the binary gcd unit on each candidate v tried, stepping it until
// one side is zero or both are even, and rejects each candidate that is
// not coprime to u; two searches (this v, then the next v) and three
// products on the shared 17x17 multiplier make up an item. An item after
// the end of the list reports exhausted without a search. A finished
// result waits in the output register while the next item is worked on.
// Limit writes are taken in any cycle and reset to 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module primitive_pythagorean_triple_generator_unit #(
  parameter int unsigned LIMIT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [LIMIT_WIDTH-1:0]      cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        restart_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pptg_pkg::OUT_W-1:0]  leg_odd_o,
  output logic [pptg_pkg::OUT_W-1:0]  leg_even_o,
  output logic [pptg_pkg::OUT_W-1:0]  hypotenuse_o,
  output logic                        is_last_o,
  output logic                        exhausted_o
);

  pptg_pkg::cmd_t    cmd;
  pptg_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  pptg_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // state, arithmetic and result register
  pptg_datapath #(
    .LIMIT_WIDTH (LIMIT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .restart_i    (restart_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .leg_odd_o    (leg_odd_o),
    .leg_even_o   (leg_even_o),
    .hypotenuse_o (hypotenuse_o),
    .is_last_o    (is_last_o),
    .exhausted_o  (exhausted_o)
  );

`ifndef NO_ASSERTIONS
  // a triple of opposite parity values has odd a and c and even b
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !exhausted_o |-> leg_odd_o[0] && hypotenuse_o[0] && !leg_even_o[0])
    else $error("triple parity broken");

  // an exhausted item carries no triple and no last mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |-> !is_last_o && (leg_odd_o == '0) &&
      (leg_even_o == '0) && (hypotenuse_o == '0))
    else $error("exhausted item carries data");

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");
`endif

endmodule
